FILE: rtl/dne_pkg.sv
// ----------------------------------------------------------------------------
// dne_pkg
// Shared types and constants for the dns name extractor: item commands,
// result status codes, octet class limits and controller/datapath links.
// ----------------------------------------------------------------------------
package dne_pkg;

  // item commands
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PARSE = 1'b1;

  // result status codes
  localparam logic ST_OK  = 1'b0;
  localparam logic ST_ERR = 1'b1;

  // octet classes: pointer lead octets and reserved label lengths
  localparam logic [7:0] PTR_MIN = 8'd192;
  localparam logic [7:0] RSV_MIN = 8'd64;

  // name store and output chunk geometry
  localparam int NAME_DEPTH  = 256;
  localparam int CHUNK_BYTES = 8;

  localparam logic [7:0] NAME_LIMIT_RST = 8'd255;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // store one packet byte
    logic start;     // begin a walk at start_pos
    logic fetch;     // read packet byte at pos, advance pos
    logic oct;       // consume a label octet or label data byte
    logic plo;       // consume the low byte of a pointer
    logic nreq;      // read one name byte
    logic ndat;      // place returned name byte in the chunk
    logic push_ok;   // load the output register with a chunk
    logic push_err;  // load the output register with an error word
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic oob;        // pos is past the packet
    logic oct_err;    // current octet breaks a rule
    logic oct_ptr;    // current octet opens a pointer
    logic oct_end;    // current octet is the terminating zero
    logic ndat_stop;  // chunk is full or name is exhausted after this byte
    logic name_done;  // every name byte has been gathered
    logic slot_free;  // output register can take a word this cycle
  } dp_sts_t;

endpackage

FILE: rtl/dne_if.sv
// ----------------------------------------------------------------------------
// dne_if
// Valid/ready channels of the dns name extractor: the item channel and the
// result channel.
// ----------------------------------------------------------------------------
interface dne_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  data_byte;
  logic        end_of_packet;
  logic [11:0] start_pos;

  modport source (output valid, cmd, data_byte, end_of_packet, start_pos, input ready);
  modport sink   (input valid, cmd, data_byte, end_of_packet, start_pos, output ready);
endinterface

interface dne_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] name_chunk;
  logic [3:0]  chunk_bytes;
  logic        chunk_last;
  logic        status;
  logic [11:0] next_pos;

  modport source (output valid, name_chunk, chunk_bytes, chunk_last, status, next_pos,
                  input ready);
  modport sink   (input valid, name_chunk, chunk_bytes, chunk_last, status, next_pos,
                  output ready);
endinterface

FILE: rtl/dns_name_extractor.sv
// ----------------------------------------------------------------------------
// dns_name_extractor
// Stores one packet and pulls a wire-form domain name out of it, following
// compression pointers.
// ----------------------------------------------------------------------------
// in_ch carries words: cmd 0 stores data_byte at the next packet position
//   (end_of_packet closes the packet and rewinds the position); cmd 1 walks
//   the name that begins at start_pos.
// out_ch returns the name in words of up to eight bytes, first byte lowest,
//   chunk_last on the final word; a bad name gives one word with status 1.
// cfg_we/cfg_data write name_limit (reset 255); the user must write it only
//   while the block is idle, which the block itself does not enforce.
// Loads are taken one per cycle while no walk runs. A walk holds in_ch off
//   until its last word sits in the output register, stepping a fetch and an
//   octet state per packet byte (registered packet store read), a request and
//   a data state per name byte from the name store, and a push per word.
// The output register decouples out_ch: a stalled receiver holds the word
//   and the walk waits for the slot, but a load or new walk can be taken
//   while the last word of the previous one is still waiting.
// Reset clears the packet length, write position and out_ch valid and sets
//   name_limit to 255; the packet store needs no clearing pass.
// ----------------------------------------------------------------------------
module dns_name_extractor #(
  parameter int PACKET_BYTES = 4096,
  parameter int READ_LIMIT   = 4096
) (
  input  logic       clk,
  input  logic       rst,
  dne_in_if.sink     in_ch,
  dne_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data
);

  dne_pkg::ctl_cmd_t cmd;
  dne_pkg::dp_sts_t  sts;

  // sequencer
  dne_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // stores, walk registers and output register
  dne_dpath #(
    .PACKET_BYTES (PACKET_BYTES),
    .READ_LIMIT   (READ_LIMIT)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .in_data_byte     (in_ch.data_byte),
    .in_end_of_packet (in_ch.end_of_packet),
    .in_start_pos     (in_ch.start_pos),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_name_chunk   (out_ch.name_chunk),
    .out_chunk_bytes  (out_ch.chunk_bytes),
    .out_chunk_last   (out_ch.chunk_last),
    .out_status       (out_ch.status),
    .out_next_pos     (out_ch.next_pos)
  );

endmodule

FILE: rtl/dne_ram.sv
// ----------------------------------------------------------------------------
// dne_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dne_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/dne_ctrl.sv
// ----------------------------------------------------------------------------
// dne_ctrl
// Sequencer of the dns name extractor: takes items, steps the label walk
// one stored byte at a time, then gathers and hands out the name chunks.
// ----------------------------------------------------------------------------
module dne_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_cmd,
  output logic                 in_ready,
  input  dne_pkg::dp_sts_t     sts,
  output dne_pkg::ctl_cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_FOCT = 9'b000000010,
    S_OCT  = 9'b000000100,
    S_FPLO = 9'b000001000,
    S_PLO  = 9'b000010000,
    S_NREQ = 9'b000100000,
    S_NDAT = 9'b001000000,
    S_PUSH = 9'b010000000,
    S_ERR  = 9'b100000000
  } state_t;

  state_t state, state_next;
  logic   take;

  assign in_ready = (state == S_IDLE);
  assign take     = in_ready && in_valid;

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (in_cmd == dne_pkg::CMD_PARSE) begin
            cmd.start  = 1'b1;
            state_next = S_FOCT;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      S_FOCT: begin
        if (sts.oob) begin
          state_next = S_ERR;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = S_OCT;
        end
      end
      S_OCT: begin
        cmd.oct = 1'b1;
        priority if (sts.oct_err) begin
          state_next = S_ERR;
        end else if (sts.oct_ptr) begin
          state_next = S_FPLO;
        end else if (sts.oct_end) begin
          state_next = S_NREQ;
        end else begin
          state_next = S_FOCT;
        end
      end
      S_FPLO: begin
        if (sts.oob) begin
          state_next = S_ERR;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = S_PLO;
        end
      end
      S_PLO: begin
        cmd.plo    = 1'b1;
        state_next = S_FOCT;
      end
      S_NREQ: begin
        cmd.nreq   = 1'b1;
        state_next = S_NDAT;
      end
      S_NDAT: begin
        cmd.ndat   = 1'b1;
        state_next = sts.ndat_stop ? S_PUSH : S_NREQ;
      end
      S_PUSH: begin
        if (sts.slot_free) begin
          cmd.push_ok = 1'b1;
          state_next  = sts.name_done ? S_IDLE : S_NREQ;
        end
      end
      S_ERR: begin
        if (sts.slot_free) begin
          cmd.push_err = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/dne_dpath.sv
// ----------------------------------------------------------------------------
// dne_dpath
// Datapath of the dns name extractor: packet and name stores, walk position
// and counters, chunk assembly and the output register.
// ----------------------------------------------------------------------------
module dne_dpath #(
  parameter int PACKET_BYTES = 4096,
  parameter int READ_LIMIT   = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  dne_pkg::ctl_cmd_t  cmd,
  output dne_pkg::dp_sts_t   sts,
  input  logic [7:0]         in_data_byte,
  input  logic               in_end_of_packet,
  input  logic [11:0]        in_start_pos,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_name_chunk,
  output logic [3:0]         out_chunk_bytes,
  output logic               out_chunk_last,
  output logic               out_status,
  output logic [11:0]        out_next_pos
);

  localparam int PW   = $clog2(PACKET_BYTES);
  localparam int POSW = (PW + 1 > 14) ? PW + 1 : 14;
  localparam int RW   = $clog2(READ_LIMIT);
  localparam int NW   = $clog2(dne_pkg::NAME_DEPTH);
  localparam int CW   = $clog2(dne_pkg::CHUNK_BYTES);

  // control state
  logic [PW-1:0] wpos;
  logic [PW:0]   plen;
  logic [7:0]    name_limit;

  // walk state
  logic [POSW-1:0] pos;
  logic [11:0]     ptr_pos;
  logic            ptr_seen;
  logic [5:0]      hi;
  logic [5:0]      rem;
  logic [NW-1:0]   nlen;
  logic [RW-1:0]   reads;

  // chunk gathering
  logic [NW-1:0]                          e;
  logic [CW:0]                            cb;
  logic [dne_pkg::CHUNK_BYTES-1:0][7:0]   chunk;

  logic [7:0] pkt_rdata;
  logic [7:0] name_rdata;
  logic       rem_nz;
  logic       is_ptr;
  logic       name_we;

  // packet store
  dne_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (wpos),
    .wdata (in_data_byte),
    .raddr (pos[PW-1:0]),
    .rdata (pkt_rdata)
  );

  // name store
  assign name_we = cmd.oct && !is_ptr;

  dne_ram #(.WIDTH(8), .DEPTH(dne_pkg::NAME_DEPTH)) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (nlen),
    .wdata (pkt_rdata),
    .raddr (e),
    .rdata (name_rdata)
  );

  // octet classification
  assign rem_nz = (rem != '0);
  assign is_ptr = !rem_nz && (pkt_rdata >= dne_pkg::PTR_MIN);

  assign sts.oob       = (pos >= POSW'(plen));
  assign sts.oct_err   = (reads == RW'(READ_LIMIT - 1))
                      || (!rem_nz && !is_ptr && (pkt_rdata >= dne_pkg::RSV_MIN))
                      || (!is_ptr && (nlen >= name_limit));
  assign sts.oct_ptr   = is_ptr;
  assign sts.oct_end   = !rem_nz && (pkt_rdata == 8'd0);
  assign sts.ndat_stop = (cb == (CW+1)'(dne_pkg::CHUNK_BYTES - 1)) || (e + 1'b1 == nlen);
  assign sts.name_done = (e == nlen);
  assign sts.slot_free = !out_valid || out_ready;

  // load position, packet length and name limit
  always_ff @(posedge clk) begin
    if (rst) begin
      wpos       <= '0;
      plen       <= '0;
      name_limit <= dne_pkg::NAME_LIMIT_RST;
    end else begin
      if (cfg_we) begin
        name_limit <= cfg_data;
      end
      if (cmd.load) begin
        if (in_end_of_packet) begin
          plen <= {1'b0, wpos} + (PW+1)'(1);
          wpos <= '0;
        end else if (wpos == PW'(PACKET_BYTES - 1)) begin
          wpos <= '0;
        end else begin
          wpos <= wpos + 1'b1;
        end
      end
    end
  end

  // walk registers and chunk assembly
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      pos      <= POSW'(in_start_pos);
      ptr_seen <= 1'b0;
      rem      <= '0;
      nlen     <= '0;
      reads    <= '0;
      e        <= '0;
      cb       <= '0;
      chunk    <= '0;
    end
    if (cmd.fetch) begin
      pos <= pos + 1'b1;
    end
    if (cmd.oct) begin
      reads <= reads + 1'b1;
      if (rem_nz) begin
        rem  <= rem - 1'b1;
        nlen <= nlen + 1'b1;
      end else if (is_ptr) begin
        hi <= pkt_rdata[5:0];
      end else begin
        rem  <= pkt_rdata[5:0];
        nlen <= nlen + 1'b1;
      end
    end
    if (cmd.plo) begin
      if (!ptr_seen) begin
        ptr_seen <= 1'b1;
        ptr_pos  <= pos[11:0];
      end
      pos <= POSW'({hi, pkt_rdata});
    end
    if (cmd.ndat) begin
      chunk[cb[CW-1:0]] <= name_rdata;
      cb                <= cb + 1'b1;
      e                 <= e + 1'b1;
    end
    if (cmd.push_ok) begin
      chunk <= '0;
      cb    <= '0;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_ok || cmd.push_err) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (cmd.push_ok) begin
      out_name_chunk  <= chunk;
      out_chunk_bytes <= cb;
      out_chunk_last  <= (e == nlen);
      out_status      <= dne_pkg::ST_OK;
      out_next_pos    <= ptr_seen ? ptr_pos : pos[11:0];
    end else if (cmd.push_err) begin
      out_name_chunk  <= '0;
      out_chunk_bytes <= '0;
      out_chunk_last  <= 1'b1;
      out_status      <= dne_pkg::ST_ERR;
      out_next_pos    <= '0;
    end
  end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for dns_name_extractor. A short table of loads and
// walks covers the corner cases of the wire-form name rules. Random packets
// of well-formed names, pointer chains, bad octets and junk follow. Every
// result word is checked against the expected word of the table or a bench
// name walker, under several name limits and random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PKT_BYTES     = 4096;
  localparam int READ_LIMIT    = 4096;
  localparam int SETTLE_CYCLES = 32;
  localparam int HOLD_CYCLES   = 400;

  // one result word as the block returns it
  typedef struct packed {
    logic [63:0] chunk;
    logic [3:0]  nbytes;
    logic        last;
    logic        st;
    logic [11:0] npos;
  } name_word_t;

  // one input word plus bench bookkeeping
  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
    logic       eop;
    logic [11:0] start;
    logic       typed;     // expected word given in the table
    name_word_t want;
    logic       set_cfg;   // write name_limit before this word
    logic [7:0] cfg_val;
  } item_t;

  localparam name_word_t ERR_WORD = {64'd0, 4'd0, 1'b1, dne_pkg::ST_ERR, 12'd0};

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [7:0] cfg_data;

  dne_in_if  in_ch();
  dne_out_if out_ch();

  dns_name_extractor #(
    .PACKET_BYTES(PKT_BYTES),
    .READ_LIMIT  (READ_LIMIT)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // bench copy of the block state
  logic [7:0]  pkt_mem [PKT_BYTES];
  logic [12:0] pkt_len = '0;
  logic [11:0] wr_pos  = '0;
  logic [7:0]  lim     = dne_pkg::NAME_LIMIT_RST;

  name_word_t pending_words[$];
  item_t      sent_items[$];
  item_t      dir_rows[$];

  // packet under construction
  logic [7:0] pkt_bytes[$];
  int         name_starts[$];
  int         bad_starts[$];

  int  in_idle, out_idle;
  bit  hold_req = 1'b0;
  int  holds_done = 0;
  int  items_sent = 0;
  int  fails = 0;
  int  n_loads = 0, n_walks = 0, n_words = 0, n_err_words = 0, n_cfg = 0;

  // walk a name from start and queue the words it should produce
  function automatic void walk_name(input logic [11:0] start);
    int unsigned pos, reads, remaining, nlen, ptr_pos, ch, target, after;
    int unsigned k, i, cnt;
    bit ptr_seen, bad, done;
    logic [7:0] nbuf [dne_pkg::NAME_DEPTH];
    name_word_t w;
    pos = 32'(start);
    reads = 0;
    remaining = 0;
    nlen = 0;
    ptr_pos = 0;
    ptr_seen = 0;
    bad = 0;
    done = 0;
    while (!bad && !done) begin
      if (pos >= pkt_len) begin
        bad = 1;
      end else begin
        ch = 32'(pkt_mem[pos]);
        pos++;
        reads++;
        if (reads >= READ_LIMIT) begin
          bad = 1;
        end else if (remaining != 0) begin
          // label data byte
          if (nlen + 1 > lim) begin
            bad = 1;
          end else begin
            nbuf[nlen] = 8'(ch);
            nlen++;
            remaining--;
          end
        end else begin
          // follow compression pointers, second byte is not counted
          while (!bad && ch >= dne_pkg::PTR_MIN) begin
            target = (ch - dne_pkg::PTR_MIN) << 8;
            if (pos >= pkt_len) begin
              bad = 1;
            end else begin
              ch = 32'(pkt_mem[pos]);
              pos++;
              if (!ptr_seen) begin
                ptr_seen = 1;
                ptr_pos = pos;
              end
              pos = target + ch;
              if (pos >= pkt_len) begin
                bad = 1;
              end else begin
                ch = 32'(pkt_mem[pos]);
                pos++;
                reads++;
                if (reads >= READ_LIMIT) bad = 1;
              end
            end
          end
          // length octet
          if (!bad) begin
            if (ch >= dne_pkg::RSV_MIN) begin
              bad = 1;
            end else if (nlen + 1 > lim) begin
              bad = 1;
            end else begin
              nbuf[nlen] = 8'(ch);
              nlen++;
              if (ch == 0) done = 1;
              else remaining = ch;
            end
          end
        end
      end
    end

    if (bad) begin
      pending_words.push_back(ERR_WORD);
    end else begin
      after = ptr_seen ? ptr_pos : pos;
      for (k = 0; k < nlen; k += dne_pkg::CHUNK_BYTES) begin
        cnt = (nlen - k > dne_pkg::CHUNK_BYTES) ? dne_pkg::CHUNK_BYTES : nlen - k;
        w.chunk = '0;
        for (i = 0; i < cnt; i++) w.chunk[8*i +: 8] = nbuf[k + i];
        w.nbytes = 4'(cnt);
        w.last   = (k + dne_pkg::CHUNK_BYTES >= nlen);
        w.st     = dne_pkg::ST_OK;
        w.npos   = 12'(after);
        pending_words.push_back(w);
      end
    end
  endfunction

  function automatic item_t load_item(input logic [7:0] d, input logic e);
    item_t it;
    it = '0;
    it.cmd   = dne_pkg::CMD_LOAD;
    it.data  = d;
    it.eop   = e;
    it.start = 12'($urandom_range(0, 4095));
    return it;
  endfunction

  function automatic item_t parse_item(input logic [11:0] s);
    item_t it;
    it = '0;
    it.cmd   = dne_pkg::CMD_PARSE;
    it.data  = 8'($urandom_range(0, 255));
    it.eop   = 1'($urandom_range(0, 1));
    it.start = s;
    return it;
  endfunction

  function automatic item_t parse_typed(input logic [11:0] s, input name_word_t w);
    item_t it;
    it = parse_item(s);
    it.typed = 1'b1;
    it.want  = w;
    return it;
  endfunction

  function automatic item_t at_limit(input logic [7:0] v, input item_t it);
    item_t r;
    r = it;
    r.set_cfg = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  // name made of the zero octet alone
  function automatic name_word_t root_word(input logic [11:0] s);
    return {64'd0, 4'd1, 1'b1, dne_pkg::ST_OK, s + 12'd1};
  endfunction

  // offer one word, with random gaps in front of it
  task automatic send(input item_t it);
    while ($urandom_range(0, 99) < in_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sent_items.push_back(it);
    in_ch.valid         <= 1'b1;
    in_ch.cmd           <= it.cmd;
    in_ch.data_byte     <= it.data;
    in_ch.end_of_packet <= it.eop;
    in_ch.start_pos     <= it.start;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // stop offering until every expected word is back, then let the block settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_words.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] v);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // random packet of names, pointer chains, bad names and junk
  task automatic build_packet(input int min_len);
    int kind, nlab, len, base, t;
    pkt_bytes.delete();
    name_starts.delete();
    bad_starts.delete();
    while (pkt_bytes.size() < min_len) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        // well-formed name, ends in a zero or points back to an earlier name
        base = name_starts.size();
        nlab = $urandom_range(0, 4);
        if (nlab == 0) name_starts.push_back(pkt_bytes.size());
        repeat (nlab) begin
          name_starts.push_back(pkt_bytes.size());
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 63) : $urandom_range(1, 10);
          pkt_bytes.push_back(8'(len));
          repeat (len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (base > 0 && $urandom_range(0, 1)) begin
          t = name_starts[$urandom_range(0, base - 1)];
          pkt_bytes.push_back(dne_pkg::PTR_MIN | {2'b00, t[13:8]});
          pkt_bytes.push_back(t[7:0]);
        end else begin
          pkt_bytes.push_back(8'h00);
        end
      end else if (kind <= 8) begin
        // broken name: reserved octet or a pointer to anywhere
        bad_starts.push_back(pkt_bytes.size());
        if ($urandom_range(0, 1)) begin
          pkt_bytes.push_back(8'h01);
          pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1)) begin
          pkt_bytes.push_back(8'($urandom_range(dne_pkg::RSV_MIN, dne_pkg::PTR_MIN - 1)));
        end else begin
          t = $urandom_range(0, 16383);
          pkt_bytes.push_back(dne_pkg::PTR_MIN | {2'b00, t[13:8]});
          pkt_bytes.push_back(t[7:0]);
        end
      end else begin
        repeat ($urandom_range(1, 4)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
      end
    end
    // sometimes a label that runs off the end
    if ($urandom_range(0, 3) == 0) begin
      bad_starts.push_back(pkt_bytes.size());
      pkt_bytes.push_back(8'($urandom_range(1, 63)));
    end
  endtask

  task automatic load_packet();
    foreach (pkt_bytes[i]) send(load_item(pkt_bytes[i], i == pkt_bytes.size() - 1));
  endtask

  // walks from name starts, bad starts and random offsets
  task automatic walk_some(input int n);
    int r;
    logic [11:0] s;
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r <= 5 && name_starts.size() > 0) begin
        s = 12'(name_starts[$urandom_range(0, name_starts.size() - 1)]);
      end else if (r <= 7 && bad_starts.size() > 0) begin
        s = 12'(bad_starts[$urandom_range(0, bad_starts.size() - 1)]);
      end else if (r == 8) begin
        s = 12'($urandom_range(0, pkt_bytes.size() - 1));
      end else begin
        s = 12'($urandom_range(0, 4095));
      end
      send(parse_item(s));
    end
  endtask

  // receiver: random ready, or a long hold-off on request
  initial begin : receiver
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        holds_done++;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= out_idle);
        @(posedge clk);
      end
    end
  end

  // check returned words, then track accepted words and config writes
  always @(posedge clk) begin : scoreboard
    name_word_t w;
    item_t acc;
    logic [11:0] nxt;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_words.size() == 0) begin
          $error("unexpected result word: name_chunk %h status %0d", out_ch.name_chunk,
                 out_ch.status);
          fails++;
        end else begin
          w = pending_words.pop_front();
          n_words++;
          if (w.st == dne_pkg::ST_ERR) n_err_words++;
          if (out_ch.name_chunk !== w.chunk) begin
            $error("name_chunk: expected %h, got %h", w.chunk, out_ch.name_chunk);
            fails++;
          end
          if (out_ch.chunk_bytes !== w.nbytes) begin
            $error("chunk_bytes: expected %0d, got %0d", w.nbytes, out_ch.chunk_bytes);
            fails++;
          end
          if (out_ch.chunk_last !== w.last) begin
            $error("chunk_last: expected %0d, got %0d", w.last, out_ch.chunk_last);
            fails++;
          end
          if (out_ch.status !== w.st) begin
            $error("status: expected %0d, got %0d", w.st, out_ch.status);
            fails++;
          end
          if (out_ch.next_pos !== w.npos) begin
            $error("next_pos: expected %0d, got %0d", w.npos, out_ch.next_pos);
            fails++;
          end
        end
      end

      if (cfg_we) begin
        lim = cfg_data;
        n_cfg++;
      end

      if (in_ch.valid && in_ch.ready) begin
        acc = sent_items.pop_front();
        if (in_ch.cmd == dne_pkg::CMD_LOAD) begin
          // store the byte, close the packet on the end mark
          pkt_mem[wr_pos] = in_ch.data_byte;
          nxt = wr_pos + 12'd1;
          if (in_ch.end_of_packet) begin
            pkt_len = (nxt == 0) ? 13'(PKT_BYTES) : {1'b0, nxt};
            wr_pos  = '0;
          end else begin
            wr_pos = nxt;
          end
          n_loads++;
        end else begin
          n_walks++;
          if (acc.typed) pending_words.push_back(acc.want);
          else walk_name(in_ch.start_pos);
        end
      end
    end
  end

  // run limit
  initial begin : watchdog
    #400_000_000;
    $display("dns_name_extractor verification failed");
    $finish;
  end

  initial begin : stimulus
    int base_items;
    int pk;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = dne_pkg::CMD_LOAD;
    in_ch.data_byte     = '0;
    in_ch.end_of_packet = 1'b0;
    in_ch.start_pos     = '0;
    cfg_we              = 1'b0;
    cfg_data            = '0;
    rst                 = 1'b1;
    in_idle  = 38;
    out_idle = 73;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: empty store, small packet, name limit edges, pointer loop
    dir_rows.push_back(parse_typed(12'd0, ERR_WORD));
    dir_rows.push_back(parse_typed(12'hFFF, ERR_WORD));
    dir_rows.push_back(load_item(8'h00, 1'b0));   // 0: root
    dir_rows.push_back(load_item(8'h01, 1'b0));   // 1: "a"
    dir_rows.push_back(load_item(8'h61, 1'b0));
    dir_rows.push_back(load_item(8'h00, 1'b0));
    dir_rows.push_back(load_item(8'hC0, 1'b0));   // 4: pointer to 1
    dir_rows.push_back(load_item(8'h01, 1'b0));
    dir_rows.push_back(load_item(8'h40, 1'b0));   // 6: lowest reserved octet
    dir_rows.push_back(load_item(8'hBF, 1'b0));   // 7: highest reserved octet
    dir_rows.push_back(load_item(8'hFF, 1'b0));   // 8: pointer to 16383
    dir_rows.push_back(load_item(8'hFF, 1'b0));
    dir_rows.push_back(load_item(8'h3F, 1'b1));   // 10: label runs off the end
    dir_rows.push_back(parse_typed(12'd0, root_word(12'd0)));
    dir_rows.push_back(parse_item(12'd1));
    dir_rows.push_back(parse_item(12'd4));
    dir_rows.push_back(parse_typed(12'd6, ERR_WORD));
    dir_rows.push_back(parse_typed(12'd7, ERR_WORD));
    dir_rows.push_back(parse_typed(12'd8, ERR_WORD));
    dir_rows.push_back(parse_typed(12'd10, ERR_WORD));
    dir_rows.push_back(at_limit(8'd1, parse_typed(12'd0, root_word(12'd0))));
    dir_rows.push_back(at_limit(8'd3, parse_item(12'd1)));
    dir_rows.push_back(at_limit(8'd2, parse_typed(12'd1, ERR_WORD)));
    // pointer to itself runs into the read limit
    dir_rows.push_back(at_limit(dne_pkg::NAME_LIMIT_RST, load_item(8'hC0, 1'b0)));
    dir_rows.push_back(load_item(8'h00, 1'b1));
    dir_rows.push_back(parse_typed(12'd0, ERR_WORD));
    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_cfg) set_limit(dir_rows[i].cfg_val);
      send(dir_rows[i]);
    end

    // random packets, the third one with a long receiver hold-off
    base_items = items_sent;
    pk = 0;
    while (items_sent < base_items + 150) begin
      if (pk == 2) hold_req = 1'b1;
      build_packet($urandom_range(12, 60));
      load_packet();
      walk_some($urandom_range(4, 12));
      pk++;
    end
    drain();

    // swap idling, new name limit per packet
    in_idle  = 73;
    out_idle = 38;
    while (items_sent < base_items + 290) begin
      set_limit(8'($urandom_range(12, 80)));
      build_packet($urandom_range(12, 60));
      load_packet();
      walk_some($urandom_range(4, 12));
    end

    // no idling, full name limit
    in_idle  = 0;
    out_idle = 0;
    set_limit(dne_pkg::NAME_LIMIT_RST);
    while (items_sent < base_items + 420) begin
      build_packet($urandom_range(12, 60));
      load_packet();
      walk_some($urandom_range(4, 12));
    end
    drain();

    $display("covered %0d packet loads and %0d name walks, %0d result words (%0d errors)",
             n_loads, n_walks, n_words, n_err_words);
    $display("name_limit written %0d times, receiver hold-offs %0d", n_cfg, holds_done);
    if (fails == 0) begin
      $display("dns_name_extractor verification clean");
    end else begin
      $display("dns_name_extractor verification failed");
    end
    $finish;
  end

endmodule

FILE: dns_name_extractor.f
rtl/dne_pkg.sv
rtl/dne_if.sv
rtl/dne_ram.sv
rtl/dne_ctrl.sv
rtl/dne_dpath.sv
rtl/dns_name_extractor.sv
tb/tb_top.sv
